@@ rtl/ksr_pkg.sv @@
// Package for the k-sums point reassignment block.
// Holds shared widths, defaults and the func codes; no dependencies.
package ksr_pkg;
    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int MAX_DIM_DEF      = 64;
    localparam int COORD_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF   = 20;
    localparam int NSUM_BITS        = 57;
    localparam int CSUM_BITS        = 36;
    localparam int PNORM_BITS       = 37;
    localparam int COST_BITS        = 60;
    localparam int CC_BITS          = 5;
    localparam int LABEL_BITS       = 4;
    localparam logic [CC_BITS-1:0] CC_RESET = 5'd16;
    localparam logic FUNC_ACCUM    = 1'b0;
    localparam logic FUNC_REASSIGN = 1'b1;
endpackage

@@ rtl/ksr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ksr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/ksums_point_reassign.sv @@
// K-sums point reassignment block: top level with buffer, sequencer and datapath.
// Depends on ksr_pkg and ksr_ram.
//
// Usage: a point arrives as a run of beats on s_axis, one signed Q8.8 coordinate
// each with the current label; tlast marks the final coordinate and tuser
// carries func. Beats are buffered, up to MAX_DIM coordinates. On the
// last beat the block works on the whole point and returns one beat on m_axis
// holding the new label, the changed flag and the best cost.
// Accumulate adds the point to its cluster: a read-modify-write of each coordinate
// sum, then of the size and norm sum. Reassign scores each cluster with one
// multiply-accumulate per coordinate through the sums memory, then moves the
// point out of its old cluster and into the best one if it changed.
// The block holds s_axis_tready low while it works on a point and while a
// result waits on a stalled m_axis. Reset clears the sizes, norm sums and
// coordinate sums with a sweep of all MAX_CLUSTERS*MAX_DIM sums addresses
// (1024 by default) during which no beat is taken; the register resets to 16.
module ksums_point_reassign #(
    parameter int MAX_CLUSTERS = ksr_pkg::MAX_CLUSTERS_DEF,
    parameter int MAX_DIM      = ksr_pkg::MAX_DIM_DEF,
    parameter int COORD_BITS   = ksr_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS   = ksr_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,          // [4:0] cluster_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] current_label, [COORD_BITS+3:4] coord
    input  logic [((ksr_pkg::LABEL_BITS + COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic        s_axis_tuser,       // [0] func
    input  logic        s_axis_tlast,       // last_coord
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata        // [3:0] new_label, [4] changed, [64:5] best_cost
);
    localparam int KB  = $clog2(MAX_CLUSTERS);
    localparam int DB  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AB  = $clog2(MAX_CLUSTERS * MAX_DIM);
    localparam int IB  = $clog2(MAX_DIM + 1);
    localparam int CB  = ksr_pkg::CSUM_BITS;
    localparam int NB  = ksr_pkg::NSUM_BITS;
    localparam int PB  = ksr_pkg::PNORM_BITS;
    localparam int TB  = ksr_pkg::COST_BITS;
    localparam int LB  = ksr_pkg::LABEL_BITS;
    localparam int SB  = COUNT_BITS + NB;
    localparam int KCB = $clog2(MAX_CLUSTERS + 1);

    localparam logic [3:0] ST_CLEAR = 4'd0, ST_IDLE = 4'd1, ST_SCAN = 4'd2,
        ST_SCORE = 4'd3, ST_MOVE = 4'd4, ST_OUT = 4'd5, ST_NEXTK = 4'd6;

    logic [3:0] state_reg, state_next;
    logic [ksr_pkg::CC_BITS-1:0] cc_reg;
    logic [PB-1:0] pnorm_reg;
    logic [IB-1:0] cidx_reg;
    logic func_reg, pass_reg, dir_reg;
    logic [KB-1:0] label_reg, k_reg, best_k_reg, move_k_reg;
    logic [KCB-1:0] cc_eff;
    logic [DB:0] d_reg;           // read address counter, one extra bit
    logic [DB:0] wd_reg;          // write-back dimension
    logic [DB:0] dims_reg;
    logic wv_reg, wv2_reg;
    logic signed [TB-1:0] best_reg, dot_reg;
    logic [AB:0] clr_reg;
    logic [LB-1:0] out_label_reg;
    logic out_chg_reg;
    logic signed [TB-1:0] out_cost_reg;
    logic [COORD_BITS-1:0] in_coord;
    logic [LB-1:0] in_label;

    assign in_label = s_axis_tdata[LB-1:0];
    assign in_coord = s_axis_tdata[LB +: COORD_BITS];

    // point buffer memory
    logic [COORD_BITS-1:0] pb_rdata;
    logic [DB-1:0] pb_raddr;
    logic pb_we;
    ksr_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_DIM)) u_pbuf (
        .clk(clk), .we(pb_we), .waddr(cidx_reg[DB-1:0]), .wdata(in_coord),
        .raddr(pb_raddr), .rdata(pb_rdata));

    // coordinate sums memory
    logic cs_we;
    logic [AB-1:0] cs_waddr, cs_raddr;
    logic [CB-1:0] cs_wdata, cs_rdata;
    ksr_ram #(.WIDTH(CB), .DEPTH(MAX_CLUSTERS * MAX_DIM)) u_csum (
        .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr), .rdata(cs_rdata));

    // cluster size and norm sum memory
    logic sn_we;
    logic [KB-1:0] sn_waddr, sn_raddr;
    logic [SB-1:0] sn_wdata, sn_rdata;
    ksr_ram #(.WIDTH(SB), .DEPTH(MAX_CLUSTERS)) u_snorm (
        .clk(clk), .we(sn_we), .waddr(sn_waddr), .wdata(sn_wdata),
        .raddr(sn_raddr), .rdata(sn_rdata));

    logic in_fire, out_fire, dims_zero;
    logic [DB:0] dims;
    logic [KB-1:0] k_sel;
    logic [KB-1:0] in_label_sat;
    logic [KCB-1:0] in_label_w;
    logic signed [COORD_BITS-1:0] xs;
    logic signed [2*COORD_BITS-1:0] xsq;
    logic signed [CB-1:0] csv;
    logic signed [CB+COORD_BITS-1:0] prod_reg;
    logic rv_reg;
    logic prod_v_reg;
    logic signed [TB-1:0] cost_val;
    logic signed [COUNT_BITS+PB:0] szn;
    logic rd_done;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = {7'd0, out_cost_reg, out_chg_reg, out_label_reg};

    // clamp cluster count into 1..MAX_CLUSTERS
    always_comb
    begin
        if (cc_reg == '0)
            cc_eff = KCB'(1);
        else if (32'(cc_reg) > MAX_CLUSTERS)
            cc_eff = KCB'(MAX_CLUSTERS);
        else
            cc_eff = KCB'(cc_reg);
    end

    // saturate label of the last beat
    assign in_label_w = KCB'(in_label);
    assign in_label_sat = (in_label_w >= cc_eff) ? KB'(cc_eff - 1'b1)
                                                 : KB'(in_label);

    // coordinate count including the final beat
    assign dims = (DB+1)'(cidx_reg) + (((32'(cidx_reg) < MAX_DIM) && in_fire) ? 1'b1 : 1'b0);
    assign dims_zero = (dims_reg == '0);
    assign xs  = in_coord;
    assign xsq = xs * xs;

    // cluster addressed by the current pass
    assign k_sel = (state_reg == ST_SCORE) ? k_reg : move_k_reg;
    assign pb_raddr = d_reg[DB-1:0];
    assign pb_we = in_fire && (32'(cidx_reg) < MAX_DIM);
    assign cs_raddr = AB'({k_sel, d_reg[DB-1:0]}) ;
    assign sn_raddr = k_sel;
    assign rd_done = (d_reg >= dims_reg);

    // multiply stage: sums word by buffered coordinate
    assign csv = cs_rdata;
    always_ff @(posedge clk)
    begin
        prod_reg <= csv * $signed(pb_rdata);
    end

    // cost for the scored cluster
    assign szn = $signed({1'b0, sn_rdata[SB-1:NB]}) * $signed({1'b0, pnorm_reg});
    assign cost_val = TB'(szn) + TB'(sn_rdata[NB-1:0]) - (dot_reg <<< 1);

    // write ports
    always_comb
    begin
        cs_we = 1'b0;
        cs_waddr = AB'({move_k_reg, wd_reg[DB-1:0]});
        cs_wdata = dir_reg ? (cs_rdata + CB'($signed(pb_rdata)))
                           : (cs_rdata - CB'($signed(pb_rdata)));
        sn_we = 1'b0;
        sn_waddr = move_k_reg;
        sn_wdata = dir_reg
            ? {sn_rdata[SB-1:NB] + 1'b1, sn_rdata[NB-1:0] + NB'(pnorm_reg)}
            : {sn_rdata[SB-1:NB] - 1'b1, sn_rdata[NB-1:0] - NB'(pnorm_reg)};
        if (state_reg == ST_CLEAR)
        begin
            cs_we = 1'b1;
            cs_waddr = clr_reg[AB-1:0];
            cs_wdata = '0;
            sn_we = (32'(clr_reg) < MAX_CLUSTERS);
            sn_waddr = clr_reg[KB-1:0];
            sn_wdata = '0;
        end
        else if (state_reg == ST_MOVE)
        begin
            cs_we = wv_reg && !wv2_reg;
            sn_we = wv2_reg;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (32'(clr_reg) == MAX_CLUSTERS * MAX_DIM - 1) state_next = ST_IDLE;
            ST_IDLE:
                if (in_fire && s_axis_tlast)
                    state_next = (s_axis_tuser == ksr_pkg::FUNC_REASSIGN) ? ST_SCORE
                                                                         : ST_MOVE;
            ST_SCORE: if (rd_done && !rv_reg && !prod_v_reg && wv_reg) state_next = ST_NEXTK;
            ST_NEXTK:
                if (32'(k_reg) + 1 >= 32'(cc_eff))
                    state_next = (best_k_reg != label_reg) ? ST_MOVE : ST_OUT;
                else
                    state_next = ST_SCORE;
            ST_MOVE:
                if (wv2_reg)
                    state_next = (pass_reg || func_reg == ksr_pkg::FUNC_ACCUM) ? ST_OUT
                                                                              : ST_MOVE;
            ST_OUT: if (out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            cc_reg <= ksr_pkg::CC_RESET;
            cidx_reg <= '0;
            pnorm_reg <= '0;
            d_reg <= '0;
            wv_reg <= 1'b0;
            wv2_reg <= 1'b0;
            rv_reg <= 1'b0;
            prod_v_reg <= 1'b0;
            pass_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                cc_reg <= cfg_wdata[ksr_pkg::CC_BITS-1:0];
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            // track read data, then product, one stage each
            rv_reg <= (state_reg == ST_SCORE) && !rd_done;
            prod_v_reg <= rv_reg;
            // buffer a coordinate
            if (in_fire)
            begin
                if (pb_we)
                    pnorm_reg <= pnorm_reg + PB'(xsq);
                if (s_axis_tlast)
                begin
                    cidx_reg <= '0;
                    d_reg <= '0;
                    wv_reg <= 1'b0;
                    wv2_reg <= 1'b0;
                    pass_reg <= 1'b0;
                end
                else if (pb_we)
                begin
                    cidx_reg <= cidx_reg + 1'b1;
                end
            end
            case (state_reg)
                ST_SCORE:
                begin
                    // issue reads, one coordinate a cycle; cost after drain
                    if (!rd_done)
                    begin
                        d_reg <= d_reg + 1'b1;
                    end
                    else if (!rv_reg && !prod_v_reg)
                    begin
                        wv_reg <= 1'b1;
                    end
                end
                ST_NEXTK:
                begin
                    d_reg <= '0;
                    wv_reg <= 1'b0;
                end
                ST_MOVE:
                begin
                    // read-modify-write one sums word at a time, then the size and norm sum
                    if (wv2_reg)
                    begin
                        wv2_reg <= 1'b0;
                        wv_reg <= 1'b0;
                        d_reg <= '0;
                        pass_reg <= 1'b1;
                    end
                    else if (!wv_reg)
                        wv_reg <= 1'b1;
                    else if (d_reg + 1'b1 >= dims_reg || dims_zero)
                    begin
                        wv2_reg <= 1'b1;
                    end
                    else
                    begin
                        d_reg <= d_reg + 1'b1;
                        wv_reg <= 1'b0;
                    end
                end
                ST_OUT:
                begin
                    pnorm_reg <= out_fire ? '0 : pnorm_reg;
                    d_reg <= '0;
                    wv_reg <= 1'b0;
                    wv2_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wd_reg <= d_reg;
        if (in_fire && s_axis_tlast)
        begin
            func_reg <= s_axis_tuser;
            label_reg <= in_label_sat;
            dims_reg <= dims;
            k_reg <= '0;
            dot_reg <= '0;
            best_reg <= '0;
            best_k_reg <= in_label_sat;
            move_k_reg <= in_label_sat;
            dir_reg <= (s_axis_tuser == ksr_pkg::FUNC_ACCUM);
        end
        if (state_reg == ST_SCORE && prod_v_reg)
            dot_reg <= dot_reg + TB'(prod_reg);
        if (state_reg == ST_SCORE && rd_done && !rv_reg && !prod_v_reg && wv_reg)
        begin
            if (k_reg == '0 || cost_val < best_reg)
            begin
                best_reg <= cost_val;
                best_k_reg <= k_reg;
            end
        end
        if (state_reg == ST_NEXTK)
        begin
            k_reg <= k_reg + 1'b1;
            dot_reg <= '0;
            move_k_reg <= label_reg;
            dir_reg <= 1'b0;
        end
        if (state_reg == ST_MOVE && wv2_reg)
        begin
            move_k_reg <= best_k_reg;
            dir_reg <= 1'b1;
        end
        if (state_reg != ST_OUT && state_next == ST_OUT)
        begin
            out_label_reg <= LB'(func_reg ? best_k_reg : label_reg);
            out_chg_reg <= func_reg && (best_k_reg != label_reg);
            out_cost_reg <= func_reg ? best_reg : '0;
        end
    end

    // a result never appears while a beat is taken
    assert property (@(posedge clk) disable iff (!rst_n) !(s_axis_tready && m_axis_tvalid))
        else $error("input and output both open");
    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // changed flag stays clear in accumulate mode
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !func_reg |-> !m_axis_tdata[4])
        else $error("changed set in accumulate mode");
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the k-sums point reassignment block.
// Depends on ksr_pkg and ksums_point_reassign; a scoreboard class predicts each result beat.
`timescale 1ns / 1ps

class ksums_scoreboard;
    int unsigned sizes [16];
    logic [56:0] norm_sums [16];
    logic [35:0] coord_sums [16][64];
    logic signed [15:0] pt [64];
    logic [36:0] pt_norm;
    int unsigned n_coords;
    logic [4:0] cc_reg;
    logic [64:0] pending [$];
    int errors;
    int checked;
    int moves;

    function new();
        cc_reg = ksr_pkg::CC_RESET;
        pt_norm = '0;
        n_coords = 0;
        errors = 0;
        checked = 0;
        moves = 0;
        foreach (sizes[k])
        begin
            sizes[k] = 0;
            norm_sums[k] = '0;
            for (int d = 0; d < 64; d++)
                coord_sums[k][d] = '0;
        end
    endfunction

    function void set_clusters(logic [4:0] v);
        cc_reg = v;
    endfunction

    // Add or remove the buffered point from cluster c.
    function void shift_point(int c, bit add);
        logic [19:0] s;
        s = sizes[c];
        s = add ? s + 20'd1 : s - 20'd1;
        sizes[c] = s;
        norm_sums[c] = add ? norm_sums[c] + 57'(pt_norm) : norm_sums[c] - 57'(pt_norm);
        for (int d = 0; d < n_coords; d++)
            coord_sums[c][d] = add ? coord_sums[c][d] + 36'(pt[d])
                                   : coord_sums[c][d] - 36'(pt[d]);
    endfunction

    // Note an accepted input beat; queue the expected result on the last coordinate.
    function void note_beat(logic func, logic [3:0] lbl, logic signed [15:0] x, logic last);
        int cc;
        int lab;
        int best_k;
        longint best;
        longint dot;
        longint cost;
        if (n_coords < 64)
        begin
            pt[n_coords] = x;
            pt_norm = pt_norm + 37'(longint'(x) * longint'(x));
            n_coords++;
        end
        if (!last)
            return;
        cc = cc_reg;
        if (cc < 1) cc = 1;
        if (cc > 16) cc = 16;
        lab = (lbl >= cc) ? cc - 1 : lbl;
        best_k = lab;
        best = 0;
        if (func == ksr_pkg::FUNC_ACCUM)
            shift_point(lab, 1);
        else
        begin
            for (int k = 0; k < cc; k++)
            begin
                dot = 0;
                for (int d = 0; d < n_coords; d++)
                    dot += longint'($signed(coord_sums[k][d])) * longint'(pt[d]);
                cost = longint'(sizes[k]) * longint'({27'd0, pt_norm})
                     + longint'({7'd0, norm_sums[k]}) - 2 * dot;
                if (k == 0 || cost < best)
                begin
                    best = cost;
                    best_k = k;
                end
            end
            if (best_k != lab)
            begin
                shift_point(lab, 0);
                shift_point(best_k, 1);
                moves++;
            end
        end
        pending.push_back({best[59:0], best_k != lab, 4'(best_k)});
        pt_norm = '0;
        n_coords = 0;
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(logic [71:0] got);
        logic [64:0] want;
        checked++;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result beat %h", got);
            return;
        end
        want = pending.pop_front();
        if (got[3:0] !== want[3:0] || got[4] !== want[4] || got[64:5] !== want[64:5])
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: label %0d/%0d changed %0b/%0b cost %0d/%0d (exp/got)",
                         want[3:0], got[3:0], want[4], got[4],
                         $signed(want[64:5]), $signed(got[64:5]));
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 4000000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // [3:0] current_label, [19:4] coord
    logic        s_axis_tuser = 0;   // [0] func
    logic        s_axis_tlast = 0;   // last_coord
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;       // [3:0] new_label, [4] changed, [64:5] best_cost

    ksums_scoreboard sb = new();
    int  cycles = 0;
    bit  no_idle = 0;
    bit  hold_rx = 0;
    int  beats_in = 0;

    ksums_point_reassign dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb failed");
            $finish;
        end
    end

    // Drive tready and check result beats.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= !hold_rx && (no_idle || $urandom_range(99) >= 18);
    end

    // Offer one beat, hold until accepted, then idle at random.
    task automatic send_beat(logic func, logic [3:0] lbl, logic [15:0] x, logic last);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {4'd0, x, lbl};
        s_axis_tuser  <= func;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_beat(func, lbl, x, last);
        beats_in++;
        if (!no_idle && $urandom_range(99) < 18)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_point(logic func, logic [3:0] lbl, int dims, int mag);
        logic [15:0] x;
        for (int d = 0; d < dims; d++)
        begin
            x = (mag == 0) ? 16'($urandom) : 16'($signed($urandom_range(2 * mag)) - mag);
            send_beat(func, lbl, x, d == dims - 1);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_clusters(logic [4:0] v);
        drain();
        cfg_we    <= 1;
        cfg_wdata <= {3'b000, v};
        @(posedge clk);
        cfg_we    <= 0;
        sb.set_clusters(v);
    endtask

    // Mostly short well-formed points with random content, some long or noisy.
    task automatic random_phase(int n);
        int dims;
        for (int i = 0; i < n; )
        begin
            dims = ($urandom_range(99) < 3) ? $urandom_range(60, 70) : $urandom_range(1, 6);
            send_point($urandom_range(99) < 40 ? ksr_pkg::FUNC_ACCUM : ksr_pkg::FUNC_REASSIGN,
                       4'($urandom), dims, ($urandom_range(9) == 0) ? 0 : 600);
            i += dims;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // Directed: extremes, both funcs, saturated labels, overlong points.
        send_beat(ksr_pkg::FUNC_ACCUM, 4'd0, 16'h7fff, 1);
        send_beat(ksr_pkg::FUNC_ACCUM, 4'd15, 16'h8000, 1);
        send_beat(ksr_pkg::FUNC_REASSIGN, 4'd15, 16'h0000, 0);
        send_beat(ksr_pkg::FUNC_ACCUM, 4'd3, 16'hffff, 1);
        send_beat(ksr_pkg::FUNC_REASSIGN, 4'd0, 16'h8000, 1);
        send_beat(ksr_pkg::FUNC_REASSIGN, 4'd15, 16'h7fff, 1);
        send_point(ksr_pkg::FUNC_ACCUM, 4'd7, 66, 0);
        send_point(ksr_pkg::FUNC_REASSIGN, 4'd2, 64, 0);
        send_point(ksr_pkg::FUNC_REASSIGN, 4'd9, 3, 300);
        write_clusters(5'd0);
        send_point(ksr_pkg::FUNC_ACCUM, 4'd5, 2, 100);
        send_point(ksr_pkg::FUNC_REASSIGN, 4'd5, 2, 100);
        write_clusters(5'd31);
        send_point(ksr_pkg::FUNC_REASSIGN, 4'd15, 2, 100);

        // Random phases over several cluster counts.
        write_clusters(5'd1);
        random_phase(120);
        write_clusters(5'd4);
        random_phase(300);
        write_clusters(5'd16);
        no_idle = 1;
        random_phase(150);
        no_idle = 0;
        random_phase(200);

        // Hold off the receiver so the block stalls its input.
        fork
            begin
                hold_rx = 1;
                repeat (400) @(posedge clk);
                hold_rx = 0;
            end
            random_phase(40);
        join
        drain();
        write_clusters(5'd9);
        random_phase(250);
        drain();

        $display("sent %0d beats, checked %0d results, %0d points moved cluster",
                 beats_in, sb.checked, sb.moves);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

@@ ksums_point_reassign.f @@
rtl/ksr_pkg.sv
rtl/ksr_ram.sv
rtl/ksums_point_reassign.sv
tb/tb.sv
